// ===== rtl/fwls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwls_pkg
// Shared codes and controller/datapath interface types for the write level
// selector.
// ----------------------------------------------------------------------------
package fwls_pkg;

	localparam int LP_W       = 12;
	localparam int LP_SPACE   = 4096;
	localparam int QUO_SHIFT  = 24;
	localparam int CNT_W      = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	localparam logic [2:0] KIND_HOST    = 3'd0;
	localparam logic [2:0] KIND_RECLAIM = 3'd1;
	localparam logic [2:0] KIND_CLOSE   = 3'd2;
	localparam logic [2:0] KIND_VICTIM  = 3'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_UNSUP    = 3'd1;
	localparam logic [2:0] ST_UNMAPPED = 3'd2;
	localparam logic [2:0] ST_NOT_OPEN = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [1:0] MODE_ADAPTIVE = 2'd0;
	localparam logic [1:0] MODE_STEP     = 2'd1;
	localparam logic [1:0] MODE_RR       = 2'd2;
	localparam logic [1:0] MODE_FIXED    = 2'd3;

	typedef struct packed {
		logic load;
		logic rd;
		logic wb;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic rsp_full;
	} sts_t;

endpackage

// ===== rtl/fwls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwls_ctrl
// Sequencer: reclaim-count clearing pass, then read / write-back per request.
// ----------------------------------------------------------------------------
module fwls_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  logic           rsp_ready,
	input  fwls_pkg::sts_t sts,
	output fwls_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_WB
	} state_t;

	state_t state_q;
	logic   can_finish;
	logic   accept;

	assign can_finish = !sts.rsp_full || rsp_ready;
	assign req_ready  = (state_q == S_IDLE) || ((state_q == S_WB) && can_finish);
	assign accept     = req_valid && req_ready;

	assign cmd.load = accept;
	assign cmd.rd   = (state_q == S_RD);
	assign cmd.wb   = (state_q == S_WB) && can_finish;
	assign cmd.clr  = (state_q == S_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WB;
				end
				S_WB: begin
					if (accept) begin
						state_q <= S_RD;
					end else if (can_finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/fwls_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwls_dp
// Datapath: page index reduction, reclaim-count memory, level stores and
// level selection, response register.
// ----------------------------------------------------------------------------
module fwls_dp #(
	parameter int LEVELS = 8,
	parameter int PAGES  = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fwls_pkg::cmd_t      cmd,
	output fwls_pkg::sts_t      sts,
	input  logic [1:0]          mode,
	input  logic [15:0]         units_per_group,
	input  logic [2:0]          kind,
	input  logic [11:0]         lp_index,
	input  logic                lp_mapped,
	input  logic [2:0]          current_level,
	input  logic [2:0]          group_level,
	input  logic [15:0]         victim_valid_units,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [2:0]          chosen_level,
	output logic                open_new,
	output logic [2:0]          status
);

	localparam int LW = $clog2(LEVELS);
	localparam int AW = $clog2(PAGES);
	localparam int PROD_W = 33;
	// reciprocal of PAGES for the index reduction; zero when no wrap occurs
	localparam logic [PROD_W-1:0] RECIP = (PAGES >= fwls_pkg::LP_SPACE) ? '0 :
		PROD_W'(((1 << fwls_pkg::QUO_SHIFT) + PAGES - 1) / PAGES);

	// request stage
	logic [2:0]        kind_s1;
	logic [11:0]       lp_s1;
	logic [7:0]        quo_s1;
	logic              mapped_s1;
	logic [LW-1:0]     cur_s1;
	logic [2:0]        grp_s1;
	logic [15:0]       vs_s1;
	logic [PROD_W-1:0] quo_prod;
	logic [LW-1:0]     cur_sat;

	// read stage
	logic [AW-1:0]     addr_s2;
	logic [7:0]        cnt_s2;
	logic [15:0]       diff_s2;
	logic              vlt_s2;
	logic              rec_s2;
	logic [11:0]       lp_red;

	// stores
	logic [7:0]        mem [PAGES];
	logic [AW-1:0]     clr_cnt_q;
	logic [LEVELS-1:0] open_q;
	logic [LEVELS-1:0] rec_q;
	logic [15:0]       vcount_q [LEVELS];
	logic [LW-1:0]     rr_q;

	// response
	logic              rsp_valid_q;
	logic [2:0]        chosen_q;
	logic              open_new_q;
	logic [2:0]        status_q;

	// write-back logic
	logic [7:0]        cnt_inc;
	logic [23:0]       wa_prod;
	logic              below;
	logic [LW-1:0]     raised;
	logic [LW-1:0]     rr_next;
	logic              grp_ok;
	logic [LW-1:0]     gi;
	logic [LW-1:0]     lvl_w;
	logic              is_write;
	logic              mem_we;
	logic [7:0]        mem_wd;
	logic              rr_adv;
	logic              clr_open;
	logic              rec_set;
	logic              set_open;
	logic [2:0]        chosen_d;
	logic [2:0]        status_d;

	assign quo_prod = PROD_W'(lp_index) * RECIP;
	assign cur_sat  = (32'(current_level) >= 32'(LEVELS)) ? LW'(LEVELS - 1) : LW'(current_level);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_s1   <= kind;
			lp_s1     <= lp_index;
			quo_s1    <= quo_prod[fwls_pkg::QUO_SHIFT +: 8];
			mapped_s1 <= lp_mapped;
			cur_s1    <= cur_sat;
			grp_s1    <= group_level;
			vs_s1     <= victim_valid_units;
		end
	end

	assign lp_red = lp_s1 - 12'(32'(quo_s1) * 32'(PAGES));

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			addr_s2 <= AW'(lp_red);
			cnt_s2  <= mem[AW'(lp_red)];
			diff_s2 <= units_per_group - vcount_q[cur_s1];
			vlt_s2  <= vcount_q[cur_s1] < units_per_group;
			rec_s2  <= rec_q[cur_s1];
		end
	end

	// write-back decision
	assign cnt_inc = (cnt_s2 == fwls_pkg::CNT_MAX) ? cnt_s2 : cnt_s2 + 8'd1;
	assign wa_prod = 24'(cnt_inc) * 24'(diff_s2);
	assign below   = !rec_s2 || (vlt_s2 && (24'(units_per_group) < wa_prod));
	assign raised  = (32'(cur_s1) + 32'd2 < 32'(LEVELS)) ? cur_s1 + LW'(1) : cur_s1;
	assign rr_next = (rr_q == LW'(LEVELS - 1)) ? '0 : rr_q + LW'(1);
	assign grp_ok  = 32'(grp_s1) < 32'(LEVELS);
	assign gi      = LW'(grp_s1);

	always_comb begin
		lvl_w    = '0;
		is_write = 1'b0;
		mem_we   = 1'b0;
		mem_wd   = '0;
		rr_adv   = 1'b0;
		clr_open = 1'b0;
		rec_set  = 1'b0;
		chosen_d = '0;
		status_d = fwls_pkg::ST_OK;
		unique case (kind_s1)
			fwls_pkg::KIND_HOST: begin
				is_write = 1'b1;
				mem_we   = 1'b1;
				unique case (mode)
					fwls_pkg::MODE_ADAPTIVE: begin
						if (!mapped_s1) begin
							lvl_w = LW'(LEVELS - 1);
						end else if (cur_s1 != '0) begin
							lvl_w = cur_s1 - LW'(1);
						end
					end
					fwls_pkg::MODE_RR: begin
						lvl_w  = rr_q;
						rr_adv = 1'b1;
					end
					default: begin
						lvl_w = mapped_s1 ? '0 : LW'(LEVELS - 1);
					end
				endcase
			end
			fwls_pkg::KIND_RECLAIM: begin
				if (!mapped_s1) begin
					status_d = fwls_pkg::ST_UNMAPPED;
				end else begin
					is_write = 1'b1;
					mem_we   = 1'b1;
					mem_wd   = cnt_inc;
					unique case (mode)
						fwls_pkg::MODE_ADAPTIVE: lvl_w = below ? raised : cur_s1;
						fwls_pkg::MODE_STEP:     lvl_w = raised;
						fwls_pkg::MODE_RR: begin
							lvl_w  = rr_q;
							rr_adv = 1'b1;
						end
						default: lvl_w = LW'(1);
					endcase
				end
			end
			fwls_pkg::KIND_CLOSE: begin
				chosen_d = grp_s1;
				if (!grp_ok || !open_q[gi]) begin
					status_d = fwls_pkg::ST_NOT_OPEN;
				end else begin
					clr_open = 1'b1;
				end
			end
			fwls_pkg::KIND_VICTIM: begin
				chosen_d = grp_s1;
				if (vs_s1 >= units_per_group) begin
					status_d = fwls_pkg::ST_FULL;
				end else if (grp_ok) begin
					rec_set = 1'b1;
				end
			end
			default: begin
				status_d = fwls_pkg::ST_UNSUP;
			end
		endcase
		if (is_write) begin
			chosen_d = 3'(lvl_w);
		end
		set_open = is_write && !open_q[lvl_w];
	end

	// reclaim-count memory, cleared by a sweep after reset
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_cnt_q] <= '0;
		end else if (cmd.wb && mem_we) begin
			mem[addr_s2] <= mem_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			rec_q  <= '0;
			rr_q   <= '0;
		end else if (cmd.wb) begin
			if (set_open) begin
				open_q[lvl_w] <= 1'b1;
			end
			if (clr_open) begin
				open_q[gi] <= 1'b0;
			end
			if (rec_set) begin
				rec_q[gi] <= 1'b1;
			end
			if (rr_adv) begin
				rr_q <= rr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb && rec_set) begin
			vcount_q[gi] <= vs_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.wb) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			chosen_q   <= chosen_d;
			open_new_q <= set_open;
			status_q   <= status_d;
		end
	end

	assign sts.clear_done = (clr_cnt_q == AW'(PAGES - 1));
	assign sts.rsp_full   = rsp_valid_q;

	assign rsp_valid    = rsp_valid_q;
	assign chosen_level = chosen_q;
	assign open_new     = open_new_q;
	assign status       = status_q;

endmodule

// ===== rtl/flash_write_level_selector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_write_level_selector_unit
// Chooses the open page-group level for host writes and reclaim rewrites;
// tracks level open flags, victim counts and per-page reclaim counts.
// A request is registered on acceptance, read, then written back into the
// response register; write-back stalls while a response is held and
// rsp_ready is low. The reclaim-count read-modify-write lets the next request
// in no sooner than the previous write-back. Reset: after arst_n, a clearing
// pass zeroes reclaim counts; no request is taken (config writes are).
// ----------------------------------------------------------------------------
module flash_write_level_selector_unit #(
	parameter int LEVELS = 8,
	parameter int PAGES  = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  kind,
	input  logic [11:0] lp_index,
	input  logic        lp_mapped,
	input  logic [2:0]  current_level,
	input  logic [2:0]  group_level,
	input  logic [15:0] victim_valid_units,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  chosen_level,
	output logic        open_new,
	output logic [2:0]  status
);

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_UPG  = 1'b1;

	logic [1:0]     mode_q;
	logic [15:0]    upg_q;
	logic           cfg_wr;
	fwls_pkg::cmd_t cmd;
	fwls_pkg::sts_t sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fwls_pkg::MODE_RR;
			upg_q  <= 16'd256;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MODE: mode_q <= pwdata[1:0];
				REG_UPG:  upg_q  <= pwdata[15:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {30'd0, mode_q};
			REG_UPG:  prdata = {16'd0, upg_q};
			default:  prdata = '0;
		endcase
	end

	fwls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fwls_dp #(
		.LEVELS (LEVELS),
		.PAGES  (PAGES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.mode               (mode_q),
		.units_per_group    (upg_q),
		.kind               (kind),
		.lp_index           (lp_index),
		.lp_mapped          (lp_mapped),
		.current_level      (current_level),
		.group_level        (group_level),
		.victim_valid_units (victim_valid_units),
		.rsp_valid          (rsp_valid),
		.rsp_ready          (rsp_ready),
		.chosen_level       (chosen_level),
		.open_new           (open_new),
		.status             (status)
	);

`ifndef SYNTHESIS
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !req_ready)
		else $error("request taken during clearing pass");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second request taken while one is in flight");

	a_open_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && open_new) |-> (status == fwls_pkg::ST_OK))
		else $error("open_new with error status");

	a_wb_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> !cmd.rd)
		else $error("read stage repeated");
`endif

endmodule

// ===== sim/tb_flash_write_level_selector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flash_write_level_selector_unit
// Self-checking bench for the write level selector. Requests are queued by
// the stimulus process and sent by a clocked driver with random gaps. Every
// accepted request runs through an in-bench model of the level choice, which
// keeps its own open flags, victim counts, round-robin pointer and per-page
// reclaim counts. Responses are compared in order. Phases cover all modes and
// the units-per-group extremes, with a reclaim-heavy adaptive phase that
// drives page counts into saturation.
// ----------------------------------------------------------------------------
module tb_flash_write_level_selector_unit;

	localparam int NLEV  = 8;
	localparam int NPAGE = 4096;

	localparam logic [2:0] KIND_OTHER = 3'd4;
	localparam logic [2:0] KIND_LAST  = 3'd7;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_UPG  = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [11:0] lp;
		logic        mapped;
		logic [2:0]  cur;
		logic [2:0]  grp;
		logic [15:0] vvu;
	} lvl_req_t;

	typedef struct packed {
		logic [2:0] level;
		logic       open_new;
		logic [2:0] status;
	} lvl_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [2:0]  kind;
	logic [11:0] lp_index;
	logic        lp_mapped;
	logic [2:0]  current_level;
	logic [2:0]  group_level;
	logic [15:0] victim_valid_units;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [2:0]  chosen_level;
	logic        open_new;
	logic [2:0]  status;

	lvl_req_t cur_req = '0;
	lvl_req_t req_backlog[$];
	lvl_rsp_t level_due[$];

	bit req_taken = 1'b0;
	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;
	int hold_left = 0;
	int bad_count = 0;

	logic [1:0]  cfg_mode = fwls_pkg::MODE_RR;
	logic [15:0] cfg_upg = 16'd256;
	int unsigned rr_ptr = 0;
	bit          lvl_open[NLEV] = '{default: 1'b0};
	bit          vic_rec[NLEV] = '{default: 1'b0};
	logic [15:0] vic_cnt[NLEV] = '{default: '0};
	logic [7:0]  reclaim_cnt[NPAGE] = '{default: '0};
	logic [11:0] lp_pool[8];
	logic [11:0] hot_lp = '0;

	assign kind               = cur_req.kind;
	assign lp_index           = cur_req.lp;
	assign lp_mapped          = cur_req.mapped;
	assign current_level      = cur_req.cur;
	assign group_level        = cur_req.grp;
	assign victim_valid_units = cur_req.vvu;

	flash_write_level_selector_unit #(
		.LEVELS(NLEV),
		.PAGES(NPAGE)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.kind(kind),
		.lp_index(lp_index),
		.lp_mapped(lp_mapped),
		.current_level(current_level),
		.group_level(group_level),
		.victim_valid_units(victim_valid_units),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.chosen_level(chosen_level),
		.open_new(open_new),
		.status(status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb_flash_write_level_selector_unit: done, errors");
		$finish;
	end

	function automatic int unsigned step_up(int unsigned lvl);
		return (lvl + 2 < NLEV) ? lvl + 1 : lvl;
	endfunction

	function automatic int unsigned next_rr();
		int unsigned v;
		v = rr_ptr % NLEV;
		rr_ptr = (v + 1) % NLEV;
		return v;
	endfunction

	function automatic lvl_rsp_t pick_write_level(lvl_req_t r);
		lvl_rsp_t    o;
		int unsigned cur, lvl, c, u, v;
		bit          below;
		o = '0;
		lvl = 0;
		cur = 32'(r.cur);
		if (cur >= NLEV)
			cur = NLEV - 1;
		case (r.kind)
			fwls_pkg::KIND_HOST: begin
				reclaim_cnt[r.lp] = '0;
				if (cfg_mode == fwls_pkg::MODE_RR)
					lvl = next_rr();
				else if (!r.mapped)
					lvl = NLEV - 1;
				else if (cfg_mode == fwls_pkg::MODE_ADAPTIVE)
					lvl = (cur != 0) ? cur - 1 : 0;
				else
					lvl = 0;
			end
			fwls_pkg::KIND_RECLAIM: begin
				if (!r.mapped) begin
					o.status = fwls_pkg::ST_UNMAPPED;
				end else begin
					c = 32'(reclaim_cnt[r.lp]);
					if (c < 32'(fwls_pkg::CNT_MAX))
						c++;
					reclaim_cnt[r.lp] = 8'(c);
					case (cfg_mode)
						fwls_pkg::MODE_ADAPTIVE: begin
							below = 1'b1;
							if (vic_rec[cur]) begin
								u = 32'(cfg_upg);
								v = 32'(vic_cnt[cur]);
								// exact form of u/(u-v) < c
								below = (v < u) && (u < c * (u - v));
							end
							lvl = below ? step_up(cur) : cur;
						end
						fwls_pkg::MODE_STEP: lvl = step_up(cur);
						fwls_pkg::MODE_RR:   lvl = next_rr();
						default:             lvl = 1;
					endcase
				end
			end
			fwls_pkg::KIND_CLOSE: begin
				lvl = 32'(r.grp);
				if (32'(r.grp) >= NLEV || !lvl_open[r.grp])
					o.status = fwls_pkg::ST_NOT_OPEN;
				else
					lvl_open[r.grp] = 1'b0;
			end
			fwls_pkg::KIND_VICTIM: begin
				lvl = 32'(r.grp);
				if (r.vvu >= cfg_upg) begin
					o.status = fwls_pkg::ST_FULL;
				end else if (32'(r.grp) < NLEV) begin
					vic_rec[r.grp] = 1'b1;
					vic_cnt[r.grp] = r.vvu;
				end
			end
			default: o.status = fwls_pkg::ST_UNSUP;
		endcase
		if ((r.kind == fwls_pkg::KIND_HOST || r.kind == fwls_pkg::KIND_RECLAIM)
				&& o.status == fwls_pkg::ST_OK) begin
			lvl = lvl % NLEV;
			if (!lvl_open[lvl]) begin
				lvl_open[lvl] = 1'b1;
				o.open_new = 1'b1;
			end
		end
		o.level = 3'(lvl);
		return o;
	endfunction

	function automatic logic [15:0] rand_valid_units();
		int unsigned s;
		s = $urandom_range(9);
		if (s < 4)
			return 16'($urandom_range(cfg_upg - 1, 0));
		else if (s == 4)
			return cfg_upg - 16'd1;
		else if (s == 5)
			return cfg_upg;
		return 16'($urandom_range(16'hFFFF));
	endfunction

	function automatic lvl_req_t rand_request(bit hammer);
		lvl_req_t    r;
		int unsigned p;
		p = $urandom_range(99);
		r.lp = ($urandom_range(9) < 7) ? lp_pool[$urandom_range(7)] : 12'($urandom_range(NPAGE - 1));
		r.mapped = ($urandom_range(99) < 85);
		r.cur = 3'($urandom_range(7));
		r.grp = 3'($urandom_range(7));
		r.vvu = rand_valid_units();
		if (hammer) begin
			// one page is reclaimed over and over without a host write
			if (p < 88) begin
				r.kind = fwls_pkg::KIND_RECLAIM;
				r.lp = hot_lp;
				r.mapped = ($urandom_range(49) != 0);
			end else if (p < 94) begin
				r.kind = fwls_pkg::KIND_VICTIM;
			end else if (p < 97) begin
				r.kind = fwls_pkg::KIND_CLOSE;
			end else begin
				r.kind = fwls_pkg::KIND_HOST;
				r.lp = hot_lp ^ 12'd1;
			end
		end else if (p < 30) begin
			r.kind = fwls_pkg::KIND_HOST;
		end else if (p < 62) begin
			r.kind = fwls_pkg::KIND_RECLAIM;
		end else if (p < 74) begin
			r.kind = fwls_pkg::KIND_CLOSE;
		end else if (p < 88) begin
			r.kind = fwls_pkg::KIND_VICTIM;
		end else begin
			r.kind = 3'($urandom_range(KIND_LAST, KIND_OTHER));
		end
		return r;
	endfunction

	task automatic flag_error(string msg);
		bad_count++;
		if (bad_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// request side: next request goes out once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (req_taken || !req_valid)) begin
			req_taken = 1'b0;
			if (req_backlog.size() > 0 && !(send_gaps && $urandom_range(99) < 37)) begin
				cur_req = req_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_ready <= !recv_gaps || ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		lvl_rsp_t want, got;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				got = '{level: chosen_level, open_new: open_new, status: status};
				if (level_due.size() == 0) begin
					flag_error($sformatf("response with no request outstanding: level %0d open_new %0d status %0d",
						got.level, got.open_new, got.status));
				end else begin
					want = level_due.pop_front();
					if (got.level !== want.level || got.open_new !== want.open_new
							|| got.status !== want.status)
						flag_error($sformatf("expected level %0d open_new %0d status %0d, got level %0d open_new %0d status %0d",
							want.level, want.open_new, want.status,
							got.level, got.open_new, got.status));
				end
			end
			if (req_valid && req_ready) begin
				level_due.insert(level_due.size(), pick_write_level(cur_req));
				req_taken = 1'b1;
			end
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == REG_MODE)
			cfg_mode = data[1:0];
		else
			cfg_upg = data[15:0];
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== data)
			flag_error($sformatf("register %0d read back %0h, wrote %0h", addr, prdata, data));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		@(posedge clk);
	endtask

	task automatic push_req(logic [2:0] k, logic [11:0] lp, logic m, logic [2:0] cur,
			logic [2:0] grp, logic [15:0] vvu);
		lvl_req_t r;
		r = '{kind: k, lp: lp, mapped: m, cur: cur, grp: grp, vvu: vvu};
		req_backlog.insert(req_backlog.size(), r);
	endtask

	task automatic drain();
		while (req_backlog.size() != 0 || req_valid || level_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(int n, bit hammer);
		repeat (n) req_backlog.insert(req_backlog.size(), rand_request(hammer));
	endtask

	initial begin
		lp_pool[0] = 12'd0;
		lp_pool[1] = 12'hFFF;
		for (int i = 2; i < 8; i++)
			lp_pool[i] = 12'($urandom_range(NPAGE - 1));
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: adaptive, 256 units per group
		write_reg(REG_MODE, 32'(fwls_pkg::MODE_ADAPTIVE));
		write_reg(REG_UPG, 32'd256);
		push_req(KIND_OTHER, 12'hFFF, 1'b1, 3'd7, 3'd7, 16'hFFFF);
		push_req(KIND_LAST, 12'hFFF, 1'b1, 3'd7, 3'd7, 16'hFFFF);
		push_req(fwls_pkg::KIND_CLOSE, 12'd0, 1'b0, 3'd0, 3'd3, 16'd0);
		push_req(fwls_pkg::KIND_HOST, 12'd0, 1'b0, 3'd0, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_HOST, 12'd1, 1'b1, 3'd0, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_HOST, 12'd2, 1'b1, 3'd7, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_RECLAIM, 12'hFFF, 1'b0, 3'd4, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_VICTIM, 12'd0, 1'b0, 3'd0, 3'd5, 16'd256);
		push_req(fwls_pkg::KIND_VICTIM, 12'd0, 1'b0, 3'd0, 3'd5, 16'd255);
		push_req(fwls_pkg::KIND_VICTIM, 12'd0, 1'b0, 3'd0, 3'd2, 16'd0);
		push_req(fwls_pkg::KIND_VICTIM, 12'd0, 1'b0, 3'd0, 3'd7, 16'hFFFF);
		push_req(fwls_pkg::KIND_RECLAIM, 12'hFFF, 1'b1, 3'd5, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_RECLAIM, 12'hFFF, 1'b1, 3'd2, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_RECLAIM, 12'd100, 1'b1, 3'd2, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_RECLAIM, 12'd100, 1'b1, 3'd6, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_RECLAIM, 12'd100, 1'b1, 3'd7, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_RECLAIM, 12'd100, 1'b1, 3'd0, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_CLOSE, 12'd0, 1'b0, 3'd0, 3'd7, 16'd0);
		push_req(fwls_pkg::KIND_CLOSE, 12'd0, 1'b0, 3'd0, 3'd7, 16'd0);
		push_req(fwls_pkg::KIND_HOST, 12'hFFF, 1'b1, 3'd3, 3'd0, 16'd0);
		push_req(fwls_pkg::KIND_RECLAIM, 12'hFFF, 1'b1, 3'd2, 3'd0, 16'd0);
		drain();

		write_reg(REG_MODE, 32'(fwls_pkg::MODE_RR));
		run_random(80, 1'b0);
		drain();

		// no gaps on either side
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		write_reg(REG_MODE, 32'(fwls_pkg::MODE_STEP));
		write_reg(REG_UPG, 32'd65535);
		run_random(80, 1'b0);
		drain();

		// receiver holds off while requests keep coming
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		write_reg(REG_MODE, 32'(fwls_pkg::MODE_FIXED));
		write_reg(REG_UPG, 32'd1);
		run_random(60, 1'b0);
		hold_left = 80;
		drain();

		hot_lp = 12'($urandom_range(NPAGE - 1));
		write_reg(REG_MODE, 32'(fwls_pkg::MODE_ADAPTIVE));
		write_reg(REG_UPG, 32'd256);
		run_random(300, 1'b0 ? 1'b0 : 1'b1);
		drain();

		write_reg(REG_UPG, 32'($urandom_range(65535, 1)));
		run_random(50, 1'b0);
		drain();
		write_reg(REG_UPG, 32'd3);
		run_random(50, 1'b0);
		drain();

		repeat (8) @(posedge clk);
		if (bad_count == 0)
			$display("tb_flash_write_level_selector_unit: done, clean");
		else
			$display("tb_flash_write_level_selector_unit: done, errors");
		$finish;
	end

endmodule
